### rtl/sjf_pkg.sv
// Field widths shared by the shortest-job-first scheduler
`timescale 1ns / 1ps

package sjf_pkg;

  // request field widths
  localparam int unsigned ARR_W  = 16;
  localparam int unsigned BUR_W  = 16;

  // result field widths
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned COMP_W = 21;
  localparam int unsigned TOT_W  = 25;

endpackage

### rtl/sjf_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module sjf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sjf_nonpreemptive_scheduler.sv
// Non-preemptive shortest-job-first scheduler: record store, scan and result stage
// Records are accepted while loading; records beyond MAX_PROCS are dropped.
// After the last record each result takes a scan of the n stored records,
// one record memory read per cycle, then an execute and a result state.
// Reset clears the record count, done flags, time and sums; the record memory
// itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module sjf_nonpreemptive_scheduler #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // record requests
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sjf_pkg::ARR_W-1:0]  arrival_time_i,
  input  logic [sjf_pkg::BUR_W-1:0]  burst_time_i,
  input  logic                       last_record_i,
  // schedule results
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sjf_pkg::IDX_W-1:0]  process_index_o,
  output logic [sjf_pkg::ARR_W-1:0]  out_arrival_o,
  output logic [sjf_pkg::BUR_W-1:0]  out_burst_o,
  output logic [sjf_pkg::COMP_W-1:0] completion_time_o,
  output logic [sjf_pkg::COMP_W-1:0] waiting_time_o,
  output logic [sjf_pkg::COMP_W-1:0] turnaround_time_o,
  output logic [sjf_pkg::TOT_W-1:0]  total_waiting_o,
  output logic [sjf_pkg::TOT_W-1:0]  total_turnaround_o,
  output logic                       last_result_o
);

  localparam int unsigned ARR_W  = sjf_pkg::ARR_W;
  localparam int unsigned BUR_W  = sjf_pkg::BUR_W;
  localparam int unsigned IDX_W  = sjf_pkg::IDX_W;
  localparam int unsigned COMP_W = sjf_pkg::COMP_W;
  localparam int unsigned TOT_W  = sjf_pkg::TOT_W;

  localparam int unsigned AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned TW = TIME_BITS + CW + 1;
  localparam int unsigned SW = TW + CW;
  localparam int unsigned DW = 2 * TIME_BITS;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EXEC,
    ST_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      issue_q, issue_d;
  logic [CW-1:0]      jobs_q, jobs_d;
  logic               pend_v_q, pend_v_d;
  logic [AW-1:0]      pend_idx_q, pend_idx_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic [TW-1:0]      time_q, time_d;
  logic [SW-1:0]      wsum_q, wsum_d;
  logic [SW-1:0]      tsum_q, tsum_d;
  logic               ba_v_q, ba_v_d;
  logic               bu_v_q, bu_v_d;
  logic               out_valid_q, out_valid_d;

  // best arrived and best not yet arrived candidates
  logic [TIME_BITS-1:0] ba_arr_q, ba_arr_d, ba_bur_q, ba_bur_d;
  logic [AW-1:0]        ba_idx_q, ba_idx_d;
  logic [TIME_BITS-1:0] bu_arr_q, bu_arr_d, bu_bur_q, bu_bur_d;
  logic [AW-1:0]        bu_idx_q, bu_idx_d;

  // executed job
  logic [AW-1:0]        ex_idx_q, ex_idx_d;
  logic [TIME_BITS-1:0] ex_arr_q, ex_arr_d, ex_bur_q, ex_bur_d;
  logic [TW-1:0]        comp_q, comp_d, wt_q, wt_d, tat_q, tat_d;

  // result register
  logic [IDX_W-1:0]  o_idx_q, o_idx_d;
  logic [ARR_W-1:0]  o_arr_q, o_arr_d;
  logic [BUR_W-1:0]  o_bur_q, o_bur_d;
  logic [COMP_W-1:0] o_comp_q, o_comp_d, o_wt_q, o_wt_d, o_tat_q, o_tat_d;
  logic [TOT_W-1:0]  o_twt_q, o_twt_d, o_ttat_q, o_ttat_d;
  logic              o_last_q, o_last_d;

  logic                 in_acc, store_en, rd_en;
  logic [DW-1:0]        rd_data;
  logic [TIME_BITS-1:0] cand_arr, cand_bur, sel_arr, sel_bur;
  logic [AW-1:0]        sel_idx;
  logic [TW-1:0]        start_t;
  logic                 cand_live, cand_arrived, fin_go, fin_last;
  logic [SW-1:0]        wsum_nx, tsum_nx;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign store_en   = in_acc && (cnt_q < CW'(MAX_PROCS));
  assign rd_en      = (state_q == ST_SCAN) && (issue_q < cnt_q);

  // record memory: burst in the upper half, arrival in the lower half
  sjf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_PROCS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({TIME_BITS'(burst_time_i), TIME_BITS'(arrival_time_i)}),
    .re_i    (rd_en),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign cand_arr     = rd_data[TIME_BITS-1:0];
  assign cand_bur     = rd_data[DW-1:TIME_BITS];
  assign cand_live    = pend_v_q && !done_q[pend_idx_q];
  assign cand_arrived = (TW'(cand_arr) <= time_q);

  // job chosen at the end of a scan; time jumps if nothing has arrived
  assign sel_idx = ba_v_q ? ba_idx_q : bu_idx_q;
  assign sel_arr = ba_v_q ? ba_arr_q : bu_arr_q;
  assign sel_bur = ba_v_q ? ba_bur_q : bu_bur_q;
  assign start_t = ba_v_q ? time_q : TW'(bu_arr_q);

  assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign fin_last = (jobs_q == cnt_q);
  assign wsum_nx  = wsum_q + SW'(wt_q);
  assign tsum_nx  = tsum_q + SW'(tat_q);

  // next-state logic
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issue_d     = issue_q;
    jobs_d      = jobs_q;
    pend_v_d    = 1'b0;
    pend_idx_d  = pend_idx_q;
    done_d      = done_q;
    time_d      = time_q;
    wsum_d      = wsum_q;
    tsum_d      = tsum_q;
    ba_v_d      = ba_v_q;
    bu_v_d      = bu_v_q;
    out_valid_d = out_valid_q;
    ba_arr_d    = ba_arr_q;
    ba_bur_d    = ba_bur_q;
    ba_idx_d    = ba_idx_q;
    bu_arr_d    = bu_arr_q;
    bu_bur_d    = bu_bur_q;
    bu_idx_d    = bu_idx_q;
    ex_idx_d    = ex_idx_q;
    ex_arr_d    = ex_arr_q;
    ex_bur_d    = ex_bur_q;
    comp_d      = comp_q;
    wt_d        = wt_q;
    tat_d       = tat_q;
    o_idx_d     = o_idx_q;
    o_arr_d     = o_arr_q;
    o_bur_d     = o_bur_q;
    o_comp_d    = o_comp_q;
    o_wt_d      = o_wt_q;
    o_tat_d     = o_tat_q;
    o_twt_d     = o_twt_q;
    o_ttat_d    = o_ttat_q;
    o_last_d    = o_last_q;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (store_en) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (in_acc && last_record_i) begin
          state_d = ST_SCAN;
          issue_d = '0;
          jobs_d  = '0;
          ba_v_d  = 1'b0;
          bu_v_d  = 1'b0;
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, evaluate the record read last cycle
        if (rd_en) begin
          issue_d    = issue_q + CW'(1);
          pend_v_d   = 1'b1;
          pend_idx_d = issue_q[AW-1:0];
        end else if (!pend_v_q) begin
          state_d = ST_EXEC;
        end
        if (cand_live && cand_arrived) begin
          if (!ba_v_q || (cand_bur < ba_bur_q) ||
              ((cand_bur == ba_bur_q) && (cand_arr < ba_arr_q))) begin
            ba_v_d   = 1'b1;
            ba_arr_d = cand_arr;
            ba_bur_d = cand_bur;
            ba_idx_d = pend_idx_q;
          end
        end
        if (cand_live && !cand_arrived) begin
          if (!bu_v_q || (cand_arr < bu_arr_q) ||
              ((cand_arr == bu_arr_q) && (cand_bur < bu_bur_q))) begin
            bu_v_d   = 1'b1;
            bu_arr_d = cand_arr;
            bu_bur_d = cand_bur;
            bu_idx_d = pend_idx_q;
          end
        end
      end

      ST_EXEC: begin
        // waiting = start - arrival, turnaround = waiting + burst
        ex_idx_d         = sel_idx;
        ex_arr_d         = sel_arr;
        ex_bur_d         = sel_bur;
        comp_d           = start_t + TW'(sel_bur);
        wt_d             = start_t - TW'(sel_arr);
        tat_d            = start_t + TW'(sel_bur) - TW'(sel_arr);
        time_d           = start_t + TW'(sel_bur);
        done_d[sel_idx]  = 1'b1;
        jobs_d           = jobs_q + CW'(1);
        state_d          = ST_FIN;
      end

      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          o_idx_d     = IDX_W'(ex_idx_q);
          o_arr_d     = ARR_W'(ex_arr_q);
          o_bur_d     = BUR_W'(ex_bur_q);
          o_comp_d    = COMP_W'(comp_q);
          o_wt_d      = COMP_W'(wt_q);
          o_tat_d     = COMP_W'(tat_q);
          o_last_d    = fin_last;
          o_twt_d     = fin_last ? TOT_W'(wsum_nx) : '0;
          o_ttat_d    = fin_last ? TOT_W'(tsum_nx) : '0;
          wsum_d      = wsum_nx;
          tsum_d      = tsum_nx;
          if (fin_last) begin
            // batch complete: back to an empty store
            state_d = ST_LOAD;
            cnt_d   = '0;
            time_d  = '0;
            wsum_d  = '0;
            tsum_d  = '0;
            done_d  = '0;
          end else begin
            state_d = ST_SCAN;
            issue_d = '0;
            ba_v_d  = 1'b0;
            bu_v_d  = 1'b0;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control state and registered valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      issue_q     <= '0;
      jobs_q      <= '0;
      pend_v_q    <= 1'b0;
      pend_idx_q  <= '0;
      done_q      <= '0;
      time_q      <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      ba_v_q      <= 1'b0;
      bu_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issue_q     <= issue_d;
      jobs_q      <= jobs_d;
      pend_v_q    <= pend_v_d;
      pend_idx_q  <= pend_idx_d;
      done_q      <= done_d;
      time_q      <= time_d;
      wsum_q      <= wsum_d;
      tsum_q      <= tsum_d;
      ba_v_q      <= ba_v_d;
      bu_v_q      <= bu_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ba_arr_q <= ba_arr_d;
    ba_bur_q <= ba_bur_d;
    ba_idx_q <= ba_idx_d;
    bu_arr_q <= bu_arr_d;
    bu_bur_q <= bu_bur_d;
    bu_idx_q <= bu_idx_d;
    ex_idx_q <= ex_idx_d;
    ex_arr_q <= ex_arr_d;
    ex_bur_q <= ex_bur_d;
    comp_q   <= comp_d;
    wt_q     <= wt_d;
    tat_q    <= tat_d;
    o_idx_q  <= o_idx_d;
    o_arr_q  <= o_arr_d;
    o_bur_q  <= o_bur_d;
    o_comp_q <= o_comp_d;
    o_wt_q   <= o_wt_d;
    o_tat_q  <= o_tat_d;
    o_twt_q  <= o_twt_d;
    o_ttat_q <= o_ttat_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign process_index_o    = o_idx_q;
  assign out_arrival_o      = o_arr_q;
  assign out_burst_o        = o_bur_q;
  assign completion_time_o  = o_comp_q;
  assign waiting_time_o     = o_wt_q;
  assign turnaround_time_o  = o_tat_q;
  assign total_waiting_o    = o_twt_q;
  assign total_turnaround_o = o_ttat_q;
  assign last_result_o      = o_last_q;

  // checks
  ap_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> ((done_q == '0) && (time_q == '0)))
    else $error("done flags or time not cleared while loading");

  ap_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_PROCS))
    else $error("record count above store depth");

  ap_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (issue_q <= cnt_q))
    else $error("scan read beyond stored records");

  ap_done_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> done_q[ex_idx_q])
    else $error("executed job not marked done");

  ap_partial_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !o_last_q) |-> ((o_twt_q == '0) && (o_ttat_q == '0)))
    else $error("totals non-zero on an intermediate result");

endmodule

### sim/tb_sjf_nonpreemptive_scheduler.sv
// Testbench for the shortest-job-first scheduler: batches of process records against a predictor
`timescale 1ns / 1ps

module tb_sjf_nonpreemptive_scheduler;

  localparam int unsigned ARR_W  = sjf_pkg::ARR_W;
  localparam int unsigned BUR_W  = sjf_pkg::BUR_W;
  localparam int unsigned IDX_W  = sjf_pkg::IDX_W;
  localparam int unsigned COMP_W = sjf_pkg::COMP_W;
  localparam int unsigned TOT_W  = sjf_pkg::TOT_W;

  localparam int unsigned PROCS     = 16;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned RAND_RECS = 117;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned DRAIN_LEN = 400;

  // one scheduled process as the block reports it
  typedef struct {
    logic [IDX_W-1:0]  proc_idx;
    logic [ARR_W-1:0]  arrival;
    logic [BUR_W-1:0]  burst;
    logic [COMP_W-1:0] completion;
    logic [COMP_W-1:0] waiting;
    logic [COMP_W-1:0] turnaround;
    logic [TOT_W-1:0]  tot_waiting;
    logic [TOT_W-1:0]  tot_turnaround;
    logic              is_last;
  } sched_result_t;

  // record store and expected schedule
  class sjf_scoreboard;
    logic [ARR_W-1:0] arr_mem [PROCS];
    logic [BUR_W-1:0] bur_mem [PROCS];
    int unsigned      rec_count;
    sched_result_t    expected_q [$];
    int unsigned      mismatches;

    function new();
      rec_count  = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // store the record; on the last one work out the whole schedule
    function void note_request(logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur, logic is_last);
      bit              ran [PROCS];
      longint unsigned now, wsum, tsum, earliest, comp, tat, wt;
      int              best;
      bit              any_ready;
      sched_result_t   res;
      if (rec_count < PROCS) begin
        arr_mem[rec_count] = arr;
        bur_mem[rec_count] = bur;
        rec_count++;
      end
      if (!is_last) return;
      foreach (ran[k]) ran[k] = 1'b0;
      now  = 0;
      wsum = 0;
      tsum = 0;
      for (int r = 0; r < rec_count; r++) begin
        // jump ahead when nothing left has arrived yet
        any_ready = 1'b0;
        earliest  = '1;
        for (int k = 0; k < rec_count; k++) begin
          if (!ran[k]) begin
            if (arr_mem[k] <= now) any_ready = 1'b1;
            if (arr_mem[k] < earliest) earliest = 64'(arr_mem[k]);
          end
        end
        if (!any_ready) now = earliest;
        // shortest burst, then earlier arrival, then lower index
        best = -1;
        for (int k = 0; k < rec_count; k++) begin
          if (!ran[k] && arr_mem[k] <= now) begin
            if (best < 0 || bur_mem[k] < bur_mem[best]
                || (bur_mem[k] == bur_mem[best] && arr_mem[k] < arr_mem[best]))
              best = k;
          end
        end
        comp = now + bur_mem[best];
        tat  = comp - arr_mem[best];
        wt   = tat - bur_mem[best];
        now  = comp;
        ran[best] = 1'b1;
        wsum += wt;
        tsum += tat;
        res.proc_idx   = IDX_W'(best);
        res.arrival    = arr_mem[best];
        res.burst      = bur_mem[best];
        res.completion = COMP_W'(comp);
        res.waiting    = COMP_W'(wt);
        res.turnaround = COMP_W'(tat);
        res.is_last    = (r == rec_count - 1);
        res.tot_waiting    = res.is_last ? TOT_W'(wsum) : '0;
        res.tot_turnaround = res.is_last ? TOT_W'(tsum) : '0;
        expected_q.push_back(res);
      end
      rec_count = 0;
    endfunction

    task check_field(string name, logic [31:0] got, logic [31:0] want,
                     logic [IDX_W-1:0] idx);
      if (got !== want)
        report($sformatf("%s got %0d expected %0d (process %0d)", name, got, want, idx));
    endtask

    task check_result(sched_result_t got);
      sched_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result for process %0d with nothing expected", got.proc_idx));
        return;
      end
      want = expected_q.pop_front();
      check_field("process_index", 32'(got.proc_idx), 32'(want.proc_idx), want.proc_idx);
      check_field("out_arrival", 32'(got.arrival), 32'(want.arrival), want.proc_idx);
      check_field("out_burst", 32'(got.burst), 32'(want.burst), want.proc_idx);
      check_field("completion_time", 32'(got.completion), 32'(want.completion),
                  want.proc_idx);
      check_field("waiting_time", 32'(got.waiting), 32'(want.waiting), want.proc_idx);
      check_field("turnaround_time", 32'(got.turnaround), 32'(want.turnaround),
                  want.proc_idx);
      check_field("total_waiting", 32'(got.tot_waiting), 32'(want.tot_waiting),
                  want.proc_idx);
      check_field("total_turnaround", 32'(got.tot_turnaround), 32'(want.tot_turnaround),
                  want.proc_idx);
      check_field("last_result", 32'(got.is_last), 32'(want.is_last), want.proc_idx);
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ARR_W-1:0]  arrival_time_i;
  logic [BUR_W-1:0]  burst_time_i;
  logic              last_record_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [IDX_W-1:0]  process_index_o;
  logic [ARR_W-1:0]  out_arrival_o;
  logic [BUR_W-1:0]  out_burst_o;
  logic [COMP_W-1:0] completion_time_o;
  logic [COMP_W-1:0] waiting_time_o;
  logic [COMP_W-1:0] turnaround_time_o;
  logic [TOT_W-1:0]  total_waiting_o;
  logic [TOT_W-1:0]  total_turnaround_o;
  logic              last_result_o;

  sjf_scoreboard sb = new();
  int unsigned   sent_count;
  int unsigned   burst_left;
  bit            hold_req;

  sjf_nonpreemptive_scheduler #(
    .MAX_PROCS(PROCS),
    .TIME_BITS(TIME_W)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .last_record_i     (last_record_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .process_index_o   (process_index_o),
    .out_arrival_o     (out_arrival_o),
    .out_burst_o       (out_burst_o),
    .completion_time_o (completion_time_o),
    .waiting_time_o    (waiting_time_o),
    .turnaround_time_o (turnaround_time_o),
    .total_waiting_o   (total_waiting_o),
    .total_turnaround_o(total_turnaround_o),
    .last_result_o     (last_result_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // offer one record, idling first when the current burst is used up
  task send_request(logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur, logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid_i     <= 1'b1;
    arrival_time_i <= arr;
    burst_time_i   <= bur;
    last_record_i  <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(arr, bur, is_last);
    sent_count++;
    burst_left--;
  endtask

  function automatic logic [15:0] extreme_value();
    case ($urandom_range(0, 2))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: check accepted results and stall on a shifting pattern
  initial begin
    int unsigned   mode_left;
    int unsigned   mode;
    int unsigned   hold_left;
    int unsigned   phase;
    sched_result_t got;
    mode_left = 0;
    mode      = 0;
    hold_left = 0;
    phase     = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.proc_idx       = process_index_o;
        got.arrival        = out_arrival_o;
        got.burst          = out_burst_o;
        got.completion     = completion_time_o;
        got.waiting        = waiting_time_o;
        got.turnaround     = turnaround_time_o;
        got.tot_waiting    = total_waiting_o;
        got.tot_turnaround = total_turnaround_o;
        got.is_last        = last_result_o;
        sb.check_result(got);
      end
      // long hold-off so the block backs up into its input
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= (phase % 4 == 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    int unsigned      size;
    int unsigned      kind;
    int unsigned      mode;
    int unsigned      batch_no;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    sent_count = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    arrival_time_i <= '0;
    burst_time_i   <= '0;
    last_record_i  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single process with zero times, then at the top of the range
    send_request(16'd0, 16'd0, 1'b1);
    send_request(16'hFFFF, 16'hFFFF, 1'b1);
    // equal bursts: earlier arrival wins, then the lower index
    send_request(16'd5, 16'd3, 1'b0);
    send_request(16'd2, 16'd3, 1'b0);
    send_request(16'd2, 16'd3, 1'b0);
    send_request(16'd10, 16'd1, 1'b1);
    // nothing arrived at time zero, so time jumps forward
    send_request(16'd100, 16'd7, 1'b0);
    send_request(16'd300, 16'd2, 1'b0);
    send_request(16'd100, 16'd7, 1'b1);
    // extremes mixed in one batch
    send_request(16'hFFFF, 16'hFFFF, 1'b0);
    send_request(16'hFFFF, 16'h0000, 1'b0);
    send_request(16'h0000, 16'hFFFF, 1'b0);
    send_request(16'hFFFF, 16'hFFFF, 1'b1);

    // random batches, mostly small, some full and some overflowing the store
    batch_no = 0;
    while (sent_count < RAND_RECS + 13) begin
      kind = $urandom_range(0, 9);
      if (kind == 0)      size = PROCS;
      else if (kind == 1) size = $urandom_range(PROCS + 1, PROCS + 3);
      else                size = $urandom_range(1, 8);
      if (batch_no == 3) begin
        size     = PROCS;
        hold_req = 1'b1;
      end
      mode = $urandom_range(0, 3);
      for (int j = 0; j < size; j++) begin
        case (mode)
          0: begin
            arr = ARR_W'($urandom_range(0, 40));
            bur = BUR_W'($urandom_range(0, 15));
          end
          1: begin
            arr = ARR_W'($urandom);
            bur = BUR_W'($urandom);
          end
          2: begin
            arr = ARR_W'($urandom);
            bur = BUR_W'($urandom_range(0, 200));
          end
          default: begin
            arr = extreme_value();
            bur = extreme_value();
          end
        endcase
        send_request(arr, bur, j == size - 1);
      end
      batch_no++;
    end
    in_valid_i <= 1'b0;

    // drain, then let any stray result show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_LEN) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
